>>> hw/rtl/fpc_pkg.sv
// Package for the frame parser with CRC-8 check.
// Holds the phase and status codes, register indexes, reset values and shared structs.
// No dependencies.
package fpc_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_CMD  = 3'd2,
        PH_PAY  = 3'd3,
        PH_CRC  = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_START_MATCH = 3'd0,
        ST_START_MISS  = 3'd1,
        ST_LENGTH      = 3'd2,
        ST_COMMAND     = 3'd3,
        ST_PAYLOAD     = 3'd4,
        ST_FRAME_GOOD  = 3'd5,
        ST_CRC_BAD     = 3'd6,
        ST_ZERO_LENGTH = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        CFG_START_COUNT   = 2'd0,
        CFG_START_PATTERN = 2'd1,
        CFG_CRC_POLY      = 2'd2
    } t_cfg_index;

    localparam logic [2:0]  START_COUNT_RESET   = 3'd2;
    localparam logic [31:0] START_PATTERN_RESET = 32'h0000_AA55;
    localparam logic [7:0]  CRC_POLY_RESET      = 8'h07;

    typedef struct packed {
        logic [2:0]  start_count;
        logic [31:0] start_pattern;
        logic [7:0]  crc_poly;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [7:0] data;
        logic [7:0] index;
        logic       frame_end;
    } t_result;

endpackage

>>> hw/rtl/fpc_crc8.sv
// Byte-wide CRC-8 update, MSB first, with a programmable generator.
// Pure combinational logic; no dependencies.
module fpc_crc8 (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_poly,
    output logic [7:0] o_crc
);

    always_comb begin
        logic [7:0] v;
        v = i_crc ^ i_byte;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ i_poly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        o_crc = v;
    end

endmodule

>>> hw/rtl/fpc_parser.sv
// Deframing state machine: start matcher, length, command, payload and CRC check.
// Depends on fpc_pkg and fpc_crc8.
module fpc_parser import fpc_pkg::*; #(
    parameter int MAX_START_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam int SW = $clog2(MAX_START_BYTES + 1);

    t_phase        r_phase, n_phase;
    logic [SW-1:0] r_match, n_match;
    logic [7:0]    r_length, n_length;
    logic [7:0]    r_count, n_count;
    logic [7:0]    r_crc, n_crc;

    logic [SW-1:0] eff_count;
    logic [SW-1:0] hunt_pos;
    logic [SW-1:0] hunt_next;
    logic          hunt_miss;
    logic [7:0]    crc_base;
    logic [7:0]    crc_new;
    logic [7:0]    count_inc;

    function automatic logic [7:0] expected_start(input logic [31:0] pattern,
                                                  input logic [SW-1:0] pos);
        logic [3:0] p4;
        p4 = 4'(pos);
        if (p4 >= 4'd4) begin
            return 8'h00;
        end
        return pattern[{p4[1:0], 3'b000} +: 8];
    endfunction

    always_comb begin
        if (i_cfg.start_count == 3'd0) begin
            eff_count = SW'(1);
        end else if (int'(i_cfg.start_count) > MAX_START_BYTES) begin
            eff_count = SW'(MAX_START_BYTES);
        end else begin
            eff_count = SW'(i_cfg.start_count);
        end

        hunt_pos  = (r_match >= eff_count) ? '0 : r_match;
        hunt_miss = 1'b0;
        if (i_byte == expected_start(i_cfg.start_pattern, hunt_pos)) begin
            hunt_next = hunt_pos + SW'(1);
        end else if (i_byte == expected_start(i_cfg.start_pattern, '0)) begin
            hunt_next = SW'(1);
        end else begin
            hunt_next = '0;
            hunt_miss = 1'b1;
        end
    end

    assign crc_base  = (r_phase == PH_CMD) ? 8'h00 : r_crc;
    assign count_inc = ((r_phase == PH_CMD) ? 8'h00 : r_count) + 8'd1;

    fpc_crc8 u_crc (
        .i_crc  (crc_base),
        .i_byte (i_byte),
        .i_poly (i_cfg.crc_poly),
        .o_crc  (crc_new)
    );

    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_length = r_length;
        n_count  = r_count;
        n_crc    = r_crc;
        o_result.status    = ST_START_MATCH;
        o_result.data      = i_byte;
        o_result.index     = 8'h00;
        o_result.frame_end = 1'b0;
        unique case (r_phase) inside
            PH_LEN: begin
                n_length = i_byte;
                n_match  = '0;
                if (i_byte == 8'h00) begin
                    o_result.status    = ST_ZERO_LENGTH;
                    o_result.frame_end = 1'b1;
                    n_phase            = PH_HUNT;
                end else begin
                    o_result.status = ST_LENGTH;
                    n_count         = 8'h00;
                    n_crc           = 8'h00;
                    n_phase         = PH_CMD;
                end
            end
            PH_CMD, PH_PAY: begin
                o_result.status = (r_phase == PH_CMD) ? ST_COMMAND : ST_PAYLOAD;
                o_result.index  = (r_phase == PH_CMD) ? 8'h00 : r_count;
                n_crc           = crc_new;
                n_count         = count_inc;
                n_phase         = (count_inc >= r_length) ? PH_CRC : PH_PAY;
            end
            PH_CRC: begin
                o_result.status    = (i_byte == r_crc) ? ST_FRAME_GOOD : ST_CRC_BAD;
                o_result.frame_end = 1'b1;
                n_phase            = PH_HUNT;
                n_match            = '0;
            end
            default: begin
                n_phase = PH_HUNT;
                n_match = hunt_next;
                if (hunt_miss) begin
                    o_result.status = ST_START_MISS;
                end else if (hunt_next >= eff_count) begin
                    n_match = '0;
                    n_phase = PH_LEN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_match  <= '0;
            r_length <= 8'h00;
            r_count  <= 8'h00;
            r_crc    <= 8'h00;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_length <= n_length;
            r_count  <= n_count;
            r_crc    <= n_crc;
        end
    end

endmodule

>>> hw/rtl/frame_parser_crc8_top.sv
// Every accepted byte gives one result; one byte per cycle sustained while the output is not stalled.
// The byte passes the input register, the parser update and the result register in that order.
// The output register lets the next byte enter while a result still waits to be taken.
// Synchronous active-low reset empties both registers, restores the register reset values
// and returns the parser to hunting for start bytes.
// Top level of the frame parser; depends on fpc_pkg and fpc_parser.
module frame_parser_crc8_top import fpc_pkg::*; #(
    parameter int MAX_START_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_data_out,
    output logic [7:0]  o_byte_index,
    output logic        o_frame_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    result;
    logic       advance;
    logic       step;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign step       = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_count   <= START_COUNT_RESET;
            r_cfg.start_pattern <= START_PATTERN_RESET;
            r_cfg.crc_poly      <= CRC_POLY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_COUNT:   r_cfg.start_count   <= i_cfg_data[2:0];
                CFG_START_PATTERN: r_cfg.start_pattern <= i_cfg_data;
                CFG_CRC_POLY:      r_cfg.crc_poly      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_byte_in;
        end
        if (step) begin
            r_out <= result;
        end
    end

    fpc_parser #(
        .MAX_START_BYTES (MAX_START_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_data_out   = r_out.data;
    assign o_byte_index = r_out.index;
    assign o_frame_end  = r_out.frame_end;

endmodule

>>> tb/sv/frame_parser_crc8_check.sv
// Checker for the frame parser: watches the byte, result and register ports,
// predicts each result from its own copy of the parser state and compares.
// Depends on fpc_pkg.
module frame_parser_crc8_check import fpc_pkg::*; #(
    parameter int MAX_START_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [7:0]  i_data_out,
    input  logic [7:0]  i_byte_index,
    input  logic        i_frame_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    t_cfg       cfg;
    t_phase     phase;
    logic [2:0] start_hits;
    logic [7:0] frame_len;
    logic [7:0] body_count;
    logic [7:0] crc_acc;
    t_result    awaited_results[$];
    int         errors;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ cfg.crc_poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [7:0] start_byte(input int pos);
        if (pos >= 4) return 8'h00;
        return cfg.start_pattern[8*pos +: 8];
    endfunction

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        int      n;
        r.status    = ST_START_MATCH;
        r.data      = b;
        r.index     = 8'h00;
        r.frame_end = 1'b0;
        case (phase)
            PH_LEN: begin
                frame_len = b;
                if (b == 8'h00) begin
                    r.status    = ST_ZERO_LENGTH;
                    r.frame_end = 1'b1;
                    phase       = PH_HUNT;
                end else begin
                    r.status   = ST_LENGTH;
                    body_count = 8'h00;
                    crc_acc    = 8'h00;
                    phase      = PH_CMD;
                end
                start_hits = 3'd0;
            end
            PH_CMD, PH_PAY: begin
                if (phase == PH_CMD) begin
                    r.status   = ST_COMMAND;
                    body_count = 8'h00;
                    crc_acc    = 8'h00;
                end else begin
                    r.status = ST_PAYLOAD;
                end
                r.index    = body_count;
                crc_acc    = crc8_next(crc_acc, b);
                body_count = body_count + 8'd1;
                phase      = (body_count >= frame_len) ? PH_CRC : PH_PAY;
            end
            PH_CRC: begin
                r.status    = (b == crc_acc) ? ST_FRAME_GOOD : ST_CRC_BAD;
                r.frame_end = 1'b1;
                phase       = PH_HUNT;
                start_hits  = 3'd0;
            end
            default: begin
                phase = PH_HUNT;
                n = (cfg.start_count == 3'd0) ? 1 : int'(cfg.start_count);
                if (n > MAX_START_BYTES) n = MAX_START_BYTES;
                if (start_hits >= n) start_hits = 3'd0;
                if (b == start_byte(start_hits)) begin
                    start_hits = start_hits + 3'd1;
                end else if (b == start_byte(0)) begin
                    start_hits = 3'd1;
                end else begin
                    start_hits = 3'd0;
                    r.status   = ST_START_MISS;
                end
                if (r.status == ST_START_MATCH && start_hits >= n) begin
                    start_hits = 3'd0;
                    phase      = PH_LEN;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg.start_count   = START_COUNT_RESET;
            cfg.start_pattern = START_PATTERN_RESET;
            cfg.crc_poly      = CRC_POLY_RESET;
            phase             = PH_HUNT;
            start_hits        = 3'd0;
            frame_len         = 8'h00;
            body_count        = 8'h00;
            crc_acc           = 8'h00;
            awaited_results.delete();
            errors            = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(deframe_byte(i_byte_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Unexpected result: status %0d data %h index %0d end %0b",
                                 i_status, i_data_out, i_byte_index, i_frame_end);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status !== i_status || want.data !== i_data_out ||
                        want.index !== i_byte_index || want.frame_end !== i_frame_end) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("Result mismatch: expected status %0d data %h index %0d",
                                     want.status, want.data, want.index,
                                     " end %0b, got status %0d data %h index %0d end %0b",
                                     want.frame_end,
                                     i_status, i_data_out, i_byte_index, i_frame_end);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_COUNT:   cfg.start_count   = i_cfg_data[2:0];
                    CFG_START_PATTERN: cfg.start_pattern = i_cfg_data;
                    CFG_CRC_POLY:      cfg.crc_poly      = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= awaited_results.size();
    end

endmodule

>>> tb/sv/frame_parser_crc8_top_tb.sv
// Testbench top for the frame parser: drives bytes, register writes and output stalls,
// and gives the verdict from the failure count of the checker.
// Depends on fpc_pkg, frame_parser_crc8_top and frame_parser_crc8_check.
module frame_parser_crc8_top_tb;
    import fpc_pkg::*;

    localparam int         MAX_START_BYTES = 4;
    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         PHASE_ITEMS     = 100;
    localparam logic [1:0] CFG_UNUSED      = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  byte_in;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [7:0]  data_out;
    logic [7:0]  byte_index;
    logic        frame_end;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    int errors;
    int pending;
    int idle_pct;
    int stall_pct;
    int items_sent;
    int cycles;
    int idle_modes[4]  = '{0, 60, 0, 11};
    int stall_modes[4] = '{0, 0, 60, 11};

    logic [2:0]  start_count;
    logic [31:0] start_pattern;
    logic [7:0]  crc_poly;

    frame_parser_crc8_top #(.MAX_START_BYTES(MAX_START_BYTES)) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_byte_in    (byte_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (status),
        .o_data_out   (data_out),
        .o_byte_index (byte_index),
        .o_frame_end  (frame_end),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    frame_parser_crc8_check #(.MAX_START_BYTES(MAX_START_BYTES)) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_byte_in    (byte_in),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_data_out   (data_out),
        .i_byte_index (byte_index),
        .i_frame_end  (frame_end),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ crc_poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic int start_len();
        int n;
        n = (start_count == 3'd0) ? 1 : int'(start_count);
        return (n > MAX_START_BYTES) ? MAX_START_BYTES : n;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [2:0] c, input logic [31:0] p, input logic [7:0] poly);
        start_count   = c;
        start_pattern = p;
        crc_poly      = poly;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_COUNT;
        cfg_data  <= {29'd0, c};
        @(posedge clk);
        cfg_index <= CFG_START_PATTERN;
        cfg_data  <= p;
        @(posedge clk);
        cfg_index <= CFG_CRC_POLY;
        cfg_data  <= {24'd0, poly};
        @(posedge clk);
        // A write beyond the register list must leave every register alone.
        cfg_index <= CFG_UNUSED;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_starts(input int count);
        for (int i = 0; i < count; i++) begin
            send_byte(start_pattern[8*i +: 8]);
        end
    endtask

    task automatic send_body(input int len, input bit bad_crc);
        logic [7:0] crc;
        logic [7:0] d;
        send_byte(len[7:0]);
        if (len == 0) return;
        crc = 8'h00;
        for (int i = 0; i < len; i++) begin
            d = 8'($urandom_range(255));
            if ($urandom_range(7) == 0) d = {8{d[0]}};
            crc = crc8_next(crc, d);
            send_byte(d);
        end
        send_byte(bad_crc ? (crc ^ (8'h01 << $urandom_range(7))) : crc);
    endtask

    task automatic send_frame(input int len, input bit bad_crc);
        send_starts(start_len());
        send_body(len, bad_crc);
    endtask

    task automatic random_config();
        logic [31:0] p;
        logic [7:0]  poly;
        case ($urandom_range(3))
            0:       p = 32'h0000_0000;
            1:       p = 32'hFFFF_FFFF;
            default: p = $urandom;
        endcase
        case ($urandom_range(3))
            0:       poly = 8'h00;
            1:       poly = 8'hFF;
            default: poly = 8'($urandom_range(255));
        endcase
        set_config(3'($urandom_range(7)), p, poly);
    endtask

    task automatic random_traffic(input int target);
        int k;
        int r;
        int len;
        while (items_sent < target) begin
            k = $urandom_range(99);
            if (k < 70) begin
                r = $urandom_range(99);
                len = (r < 85) ? $urandom_range(1, 8) : (r < 97) ? $urandom_range(9, 40) : 0;
                send_frame(len, $urandom_range(99) < 15);
            end else if (k < 80) begin
                send_starts($urandom_range(0, start_len() - 1));
                send_byte(8'($urandom_range(255)));
            end else if (k < 90) begin
                send_starts(start_len());
                len = $urandom_range(2, 8);
                send_byte(len[7:0]);
                repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        byte_in   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_START_COUNT;
        cfg_data  <= 32'd0;
        start_count   = START_COUNT_RESET;
        start_pattern = START_PATTERN_RESET;
        crc_poly      = CRC_POLY_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_body(2, 1'b0);
        send_frame(1, 1'b1);

        drain();
        set_config(3'd0, 32'hFFFF_FFFF, 8'hFF);
        send_frame(3, 1'b0);
        drain();
        set_config(3'd7, 32'h0000_0000, 8'h00);
        send_frame(1, 1'b0);

        // Lowering the start count while the matcher holds more bytes restarts the hunt.
        drain();
        set_config(3'd4, 32'h0403_0201, 8'h07);
        send_starts(3);
        drain();
        set_config(3'd1, 32'h0403_0201, 8'h07);
        send_frame(2, 1'b0);

        for (int round = 0; round < 2; round++) begin
            for (int mode = 0; mode < 4; mode++) begin
                drain();
                idle_pct  = idle_modes[mode];
                stall_pct = stall_modes[mode];
                random_config();
                if (round == 1 && mode == 0) send_frame(255, 1'b0);
                random_traffic(items_sent + PHASE_ITEMS);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/fpc_pkg.sv
hw/rtl/fpc_crc8.sv
hw/rtl/fpc_parser.sv
hw/rtl/frame_parser_crc8_top.sv
tb/sv/frame_parser_crc8_check.sv
tb/sv/frame_parser_crc8_top_tb.sv
